@@ rtl/core/wsc_pkg.sv @@
// Shared types and constants of the wavetable sound channel.
// No dependencies; used by the top level through scoped names.
package wsc_pkg;

    localparam int TABLE_ENTRIES = 32;

    localparam logic [15:0] SAMPLE_STEP_RESET = 16'd12174;

    localparam int FREQ_W   = 11;
    localparam int PERIOD_W = 20;
    localparam int TIME_W   = 32;

    localparam logic [11:0] PERIOD_BASE = 12'd2048;
    localparam logic [7:0]  LEN_RELOAD  = 8'hFF;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_SAMPLE = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        VOL_MUTE    = 2'd0,
        VOL_FULL    = 2'd1,
        VOL_HALF    = 2'd2,
        VOL_QUARTER = 2'd3
    } vol_t;

    localparam logic [15:0] ADDR_ENABLE   = 16'hFF1A;
    localparam logic [15:0] ADDR_LENGTH   = 16'hFF1B;
    localparam logic [15:0] ADDR_VOLUME   = 16'hFF1C;
    localparam logic [15:0] ADDR_FREQ_LO  = 16'hFF1D;
    localparam logic [15:0] ADDR_FREQ_HI  = 16'hFF1E;
    localparam logic [15:0] ADDR_TABLE_LO = 16'hFF30;
    localparam logic [15:0] ADDR_TABLE_HI = 16'hFF3F;

endpackage

@@ rtl/core/wsc_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// Self-contained; no package needed. Collisions return the old contents.
module wsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/core/wavetable_sound_channel.sv @@
// Wavetable sound channel top level: bus registers, length counter, sample stage.
// Depends on wsc_pkg and wsc_ram (16-byte wave table, two nibbles per byte).
// Pipeline: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the output stalls; the table RAM has registered reads with write bypass.
// Reset: control and channel state clear, sample_step returns to 12174.
// Reset leaves the wave table contents undefined until written; no clearing pass.
module wavetable_sound_channel #(
    parameter int TABLE_ENTRIES = wsc_pkg::TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] sample_step,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] addr,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic [5:0]  sample_level,
    output logic        channel_on
);

    localparam int PTR_W   = $clog2(TABLE_ENTRIES);
    localparam int BYTES   = TABLE_ENTRIES / 2;
    localparam int BYTE_AW = $clog2(BYTES);
    localparam int FREQ_W  = wsc_pkg::FREQ_W;
    localparam int PER_W   = wsc_pkg::PERIOD_W;
    localparam int TIME_W  = wsc_pkg::TIME_W;

    // handshake and stage control
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              s1_adv;
    logic              proc;
    logic              in_fire;

    // input stage
    wsc_pkg::act_t     act_reg;
    logic [15:0]       addr_reg;
    logic [7:0]        data_reg;
    logic              fwd_a_reg;
    logic              fwd_b_reg;
    logic [7:0]        fwd_data_reg;

    // channel state
    logic [15:0]       step_reg;
    logic              en_reg,        en_next;
    logic [7:0]        len_load_reg,  len_load_next;
    logic [7:0]        len_cnt_reg,   len_cnt_next;
    logic [7:0]        vol_reg,       vol_next;
    logic [7:0]        fhi_reg,       fhi_next;
    logic [FREQ_W-1:0] freq_reg,      freq_next;
    logic [PER_W-1:0]  period_reg,    period_next;
    logic [PTR_W-1:0]  ptr_reg,       ptr_next;
    logic [TIME_W-1:0] elapsed_reg,   elapsed_next;
    logic              parity_reg,    parity_next;

    // result register
    logic [7:0]        rd_reg,        rd_next;
    logic [5:0]        level_reg,     level_next;
    logic              on_reg;

    // table access
    logic              ram_we;
    logic [BYTE_AW-1:0] ram_waddr;
    logic [BYTE_AW-1:0] raddr_a;
    logic [BYTE_AW-1:0] raddr_b;
    logic [7:0]        ram_rdata_a;
    logic [7:0]        ram_rdata_b;
    logic [7:0]        bus_byte;
    logic [7:0]        samp_byte;
    logic [3:0]        entry;
    logic              in_table;
    logic [PTR_W-1:0]  ptr_addr;

    // sample arithmetic
    logic [TIME_W:0]   sum_ext;
    logic [TIME_W-1:0] sum_sat;
    logic [TIME_W:0]   diff_ext;
    logic [7:0]        len_dec;
    logic [PER_W-1:0]  period_latch;
    wsc_pkg::vol_t     vol_code;

    assign s1_adv    = !out_valid_reg || out_ready;
    assign proc      = in_valid_reg && s1_adv;
    assign in_ready  = !in_valid_reg || s1_adv;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign in_table  = (addr_reg >= wsc_pkg::ADDR_TABLE_LO) &&
                       (addr_reg <= wsc_pkg::ADDR_TABLE_HI);
    assign ram_waddr = addr_reg[BYTE_AW-1:0];
    assign ram_we    = proc && (act_reg == wsc_pkg::ACT_WRITE) && in_table && !en_reg;

    // the sample read address looks ahead at the pointer the current item leaves behind
    assign ptr_addr  = proc ? ptr_next : ptr_reg;
    assign raddr_a   = addr[BYTE_AW-1:0];
    assign raddr_b   = ptr_addr[PTR_W-1:1];

    wsc_ram #(
        .WIDTH (8),
        .DEPTH (BYTES)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (data_reg),
        .re      (in_fire),
        .raddr_a (raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign bus_byte  = fwd_a_reg ? fwd_data_reg : ram_rdata_a;
    assign samp_byte = fwd_b_reg ? fwd_data_reg : ram_rdata_b;
    // even entries sit in the high nibble
    assign entry     = ptr_reg[0] ? samp_byte[3:0] : samp_byte[7:4];
    assign vol_code  = wsc_pkg::vol_t'(vol_reg[6:5]);

    assign sum_ext   = {1'b0, elapsed_reg} + {{(TIME_W+1-16){1'b0}}, step_reg};
    assign sum_sat   = sum_ext[TIME_W] ? {TIME_W{1'b1}} : sum_ext[TIME_W-1:0];
    assign diff_ext  = {1'b0, sum_sat} - {{(TIME_W+1-PER_W){1'b0}}, period_reg};
    assign len_dec   = len_cnt_reg - 8'd1;

    always_comb
    begin
        en_next       = en_reg;
        len_load_next = len_load_reg;
        len_cnt_next  = len_cnt_reg;
        vol_next      = vol_reg;
        fhi_next      = fhi_reg;
        freq_next     = freq_reg;
        period_next   = period_reg;
        ptr_next      = ptr_reg;
        elapsed_next  = elapsed_reg;
        parity_next   = parity_reg;
        rd_next       = 8'h00;
        level_next    = 6'd0;
        period_latch  = '0;

        unique case (act_reg)
            wsc_pkg::ACT_WRITE:
            begin
                unique case (addr_reg)
                    wsc_pkg::ADDR_ENABLE:
                    begin
                        en_next = data_reg[7];
                    end
                    wsc_pkg::ADDR_LENGTH:
                    begin
                        len_load_next = data_reg;
                        len_cnt_next  = data_reg;
                    end
                    wsc_pkg::ADDR_VOLUME:
                    begin
                        vol_next = data_reg;
                    end
                    wsc_pkg::ADDR_FREQ_LO:
                    begin
                        freq_next    = {freq_reg[FREQ_W-1:8], data_reg};
                        period_latch = {wsc_pkg::PERIOD_BASE - {1'b0, freq_next}, 8'h00};
                        period_next  = period_latch;
                    end
                    wsc_pkg::ADDR_FREQ_HI:
                    begin
                        fhi_next  = data_reg;
                        freq_next = {data_reg[2:0], freq_reg[7:0]};
                        if (data_reg[7])
                        begin
                            // restart: rewind the table, reload an expired length and relatch the period
                            ptr_next     = '0;
                            elapsed_next = '0;
                            if (len_cnt_reg == 8'd0)
                            begin
                                len_cnt_next = wsc_pkg::LEN_RELOAD;
                            end
                            period_latch = {wsc_pkg::PERIOD_BASE - {1'b0, freq_next}, 8'h00};
                            period_next  = period_latch;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            wsc_pkg::ACT_READ:
            begin
                unique case (addr_reg)
                    wsc_pkg::ADDR_ENABLE:  rd_next = {en_reg, 7'd0};
                    wsc_pkg::ADDR_LENGTH:  rd_next = len_load_reg;
                    wsc_pkg::ADDR_VOLUME:  rd_next = vol_reg;
                    wsc_pkg::ADDR_FREQ_LO: rd_next = freq_reg[7:0];
                    wsc_pkg::ADDR_FREQ_HI: rd_next = fhi_reg;
                    default:
                    begin
                        if (in_table && !en_reg)
                        begin
                            rd_next = bus_byte;
                        end
                    end
                endcase
            end
            wsc_pkg::ACT_TICK:
            begin
                if (en_reg)
                begin
                    if ((len_cnt_reg != 8'd0) && !parity_reg)
                    begin
                        len_cnt_next = len_dec;
                        if (len_dec == 8'd0)
                        begin
                            if (fhi_reg[6])
                            begin
                                en_next = 1'b0;
                            end
                            else
                            begin
                                len_cnt_next = len_load_reg;
                            end
                        end
                    end
                    parity_next = !parity_reg;
                end
            end
            wsc_pkg::ACT_SAMPLE:
            begin
                if (en_reg && (vol_code != wsc_pkg::VOL_MUTE))
                begin
                    case (vol_code)
                        wsc_pkg::VOL_FULL: level_next = {entry, 2'b00};
                        wsc_pkg::VOL_HALF: level_next = {1'b0, entry, 1'b0};
                        default:           level_next = {2'b00, entry};
                    endcase
                    elapsed_next = sum_sat;
                    // borrow clear means a full period has elapsed
                    if (!diff_ext[TIME_W])
                    begin
                        ptr_next     = ptr_reg + PTR_W'(1);
                        elapsed_next = diff_ext[TIME_W-1:0];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= wsc_pkg::SAMPLE_STEP_RESET;
            en_reg        <= 1'b0;
            len_load_reg  <= 8'd0;
            len_cnt_reg   <= 8'd0;
            vol_reg       <= 8'd0;
            fhi_reg       <= 8'd0;
            freq_reg      <= '0;
            period_reg    <= '0;
            ptr_reg       <= '0;
            elapsed_reg   <= '0;
            parity_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                step_reg <= sample_step;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (proc)
            begin
                en_reg       <= en_next;
                len_load_reg <= len_load_next;
                len_cnt_reg  <= len_cnt_next;
                vol_reg      <= vol_next;
                fhi_reg      <= fhi_next;
                freq_reg     <= freq_next;
                period_reg   <= period_next;
                ptr_reg      <= ptr_next;
                elapsed_reg  <= elapsed_next;
                parity_reg   <= parity_next;
            end
        end
    end

    // payload and result registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg      <= wsc_pkg::act_t'(action);
            addr_reg     <= addr;
            data_reg     <= write_data;
            // bypass a table write that lands on the same edge as the read
            fwd_a_reg    <= ram_we && (ram_waddr == raddr_a);
            fwd_b_reg    <= ram_we && (ram_waddr == raddr_b);
            fwd_data_reg <= data_reg;
        end
        if (proc)
        begin
            rd_reg    <= rd_next;
            level_reg <= level_next;
            on_reg    <= en_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rd_reg;
    assign sample_level = level_reg;
    assign channel_on   = on_reg;

    a_table_locked: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !en_reg)
        else $error("table written while channel enabled");

    a_restart_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && (act_reg == wsc_pkg::ACT_WRITE) && (addr_reg == wsc_pkg::ADDR_FREQ_HI)
         && data_reg[7]) |=> ((ptr_reg == '0) && (elapsed_reg == '0) && (len_cnt_reg != 8'd0)))
        else $error("restart did not rewind channel state");

    a_level_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && (level_next != 6'd0)) |-> (en_reg && (act_reg == wsc_pkg::ACT_SAMPLE)))
        else $error("sample level produced while silent");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !s1_adv) |=> (in_valid_reg && $stable(addr_reg)))
        else $error("input stage lost a stalled item");

    a_state_frozen_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> ($stable(ptr_reg) && $stable(en_reg)))
        else $error("channel state changed without an item");

endmodule
